// ----- rtl/bemt_pkg.sv -----
// Shared constants and codes for the extent map translate block.
// No dependencies; used by the top level, the divider and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bemt_pkg;

   // Table geometry
   localparam int MAX_EXTENTS = 64;
   localparam int IDX_W       = $clog2(MAX_EXTENTS);
   localparam int CNT_W       = IDX_W + 1;

   // Field widths
   localparam int ADDR_W  = 48;
   localparam int ITEM_W  = 32;
   localparam int BPI_W   = 16;
   localparam int ENT_W   = ADDR_W + ITEM_W;
   localparam int PROD_W  = ITEM_W + BPI_W;
   localparam int NT_W    = ADDR_W + 3;
   localparam int DVD_W   = NT_W - 1;
   localparam int RADDR_W = 49;
   localparam int RCNT_W  = 33;
   localparam int RIDX_W  = 7;

   // Request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_FIND  = 2'd2;
   localparam logic [1:0] REQ_XLATE = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_PAST = 2'd2;

   // Saturation limits of the items-remaining field
   localparam logic [RCNT_W-1:0] RCNT_MAX = {1'b0, {(RCNT_W-1){1'b1}}};
   localparam logic [RCNT_W-1:0] RCNT_MIN = {1'b1, {(RCNT_W-1){1'b0}}};

endpackage

`default_nettype wire

// ----- rtl/block_extent_map_translate.sv -----
// Extent map with find and address translation; top level and sequencer.
// Depends on bemt_pkg, bemt_ram (extent table) and bemt_div (item divider).
// A write, a read miss and a find or translate on an empty table are answered from idle with
// busy low. Else a read runs fetch, load; find runs fetch, load, add, compare per extent
// examined; translate runs fetch, load, add, subtract per extent walked, then the divider
// at one quotient bit per cycle over 50 bits. Each extent visit is bound by the one table
// read port and the one shared 51-bit adder. One request at a time; the receiver cannot stall.
// Synchronous reset empties the table at once (per-entry valid bits); item size resets to 1.
`timescale 1ns / 1ps
`default_nettype none

module block_extent_map_translate (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // Request channel
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [1:0]                              req_type,
   input  wire logic [5:0]                              req_block_index,
   input  wire logic [bemt_pkg::ADDR_W-1:0]             req_address,
   input  wire logic [bemt_pkg::ITEM_W-1:0]             req_item_count,
   // Result channel
   output logic                                         rsp_valid,
   output logic signed [bemt_pkg::RADDR_W-1:0]          rsp_result_addr,
   output logic signed [bemt_pkg::RCNT_W-1:0]           rsp_result_count,
   output logic signed [bemt_pkg::RIDX_W-1:0]           rsp_result_index,
   output logic [1:0]                                   rsp_status,
   // Configuration channel
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [bemt_pkg::BPI_W-1:0]              csr_data
);

   localparam int AW   = bemt_pkg::ADDR_W;
   localparam int NW   = bemt_pkg::NT_W;
   localparam int CW   = bemt_pkg::CNT_W;
   localparam int IW   = bemt_pkg::IDX_W;
   localparam int QW   = bemt_pkg::DVD_W;
   localparam int RCW  = bemt_pkg::RCNT_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_ADD   = 4'd3;
   localparam logic [3:0] S_CMP   = 4'd4;
   localparam logic [3:0] S_SUB   = 4'd5;
   localparam logic [3:0] S_DIVS  = 4'd6;
   localparam logic [3:0] S_DIVW  = 4'd7;

   // Control state
   logic [3:0]                          state_ff, state_in;
   logic [CW-1:0]                       in_use_ff, in_use_in;
   logic [bemt_pkg::MAX_EXTENTS-1:0]    valid_ff, valid_in;
   logic [bemt_pkg::BPI_W-1:0]          bpi_ff, bpi_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Request and walk registers
   logic [1:0]                          op_ff, op_in;
   logic [CW-1:0]                       idx_ff, idx_in;
   logic [AW-1:0]                       addr_ff, addr_in;
   logic                                first_ff, first_in;
   logic                                vld_ff;
   logic [AW-1:0]                       ent_addr_ff, ent_addr_in;
   logic [bemt_pkg::ITEM_W-1:0]         ent_cnt_ff, ent_cnt_in;
   logic [bemt_pkg::PROD_W-1:0]         prod_ff, prod_in;
   logic [AW:0]                         stop_ff, stop_in;
   logic [NW-1:0]                       nt_ff, nt_in;
   logic [AW-1:0]                       eaddr_ff, eaddr_in;

   // Result registers
   logic signed [bemt_pkg::RADDR_W-1:0] res_addr_ff, res_addr_in;
   logic signed [RCW-1:0]               res_cnt_ff, res_cnt_in;
   logic signed [bemt_pkg::RIDX_W-1:0]  res_idx_ff, res_idx_in;
   logic [1:0]                          res_st_ff, res_st_in;

   // Table port
   logic                                ram_we;
   logic [IW-1:0]                       ram_waddr;
   logic [bemt_pkg::ENT_W-1:0]          ram_wdata;
   logic                                ram_re;
   logic [bemt_pkg::ENT_W-1:0]          ram_rdata;

   // Shared adder
   logic [NW-1:0]                       add_a, add_b, add_sum;
   logic                                add_sub;

   // Divider
   logic                                div_start;
   logic [QW-1:0]                       div_dvd;
   logic                                div_done;
   logic [QW-1:0]                       div_quo;

   // Misc combinational
   logic                                accept;
   logic [bemt_pkg::BPI_W-1:0]          bpi_eff;
   logic [AW-1:0]                       ld_addr;
   logic [bemt_pkg::ITEM_W-1:0]         ld_cnt;
   logic [CW-1:0]                       idx_nx;
   logic [CW-1:0]                       req_idx;
   logic [RCW-1:0]                      q_sat;

   assign accept  = start && (state_ff == S_IDLE);
   assign bpi_eff = (bpi_ff == '0) ? bpi_ff + bemt_pkg::BPI_W'(1) : bpi_ff;
   assign idx_nx  = idx_ff + CW'(1);
   assign req_idx = CW'(req_block_index);

   // Entries never written read as no address and no items
   assign ld_addr = vld_ff ? ram_rdata[bemt_pkg::ENT_W-1:bemt_pkg::ITEM_W] : '1;
   assign ld_cnt  = vld_ff ? ram_rdata[bemt_pkg::ITEM_W-1:0] : '0;

   bemt_ram #(
      .WIDTH (bemt_pkg::ENT_W),
      .DEPTH (bemt_pkg::MAX_EXTENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   bemt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (bpi_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Steer the shared adder by step
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         S_ADD: begin
            if (op_ff == bemt_pkg::REQ_FIND) begin
               add_a = NW'(ent_addr_ff);
               add_b = NW'(prod_ff);
            end else if (first_ff) begin
               add_a   = NW'(addr_ff);
               add_b   = NW'(ent_addr_ff);
               add_sub = 1'b1;
            end else begin
               add_a = NW'(ent_addr_ff);
               add_b = nt_ff;
            end
         end
         S_SUB: begin
            add_a   = nt_ff;
            add_b   = NW'(prod_ff);
            add_sub = 1'b1;
         end
         S_DIVS: begin
            add_b   = nt_ff;
            add_sub = 1'b1;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + NW'(add_sub);

   // Saturate the signed quotient; a negative offset gives a positive count
   always_comb begin
      if (nt_ff[NW-1]) begin
         q_sat = (|div_quo[QW-1:RCW-1]) ? bemt_pkg::RCNT_MAX : RCW'(div_quo);
      end else if ((|div_quo[QW-1:RCW]) || (div_quo[RCW-1] && (|div_quo[RCW-2:0]))) begin
         q_sat = bemt_pkg::RCNT_MIN;
      end else begin
         q_sat = ~div_quo[RCW-1:0] + RCW'(1);
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      in_use_in    = in_use_ff;
      valid_in     = valid_ff;
      bpi_in       = bpi_ff;
      rsp_valid_in = 1'b0;
      op_in        = op_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      first_in     = first_ff;
      ent_addr_in  = ent_addr_ff;
      ent_cnt_in   = ent_cnt_ff;
      prod_in      = prod_ff;
      stop_in      = stop_ff;
      nt_in        = nt_ff;
      eaddr_in     = eaddr_ff;
      res_addr_in  = res_addr_ff;
      res_cnt_in   = res_cnt_ff;
      res_idx_in   = res_idx_ff;
      res_st_in    = res_st_ff;
      ram_we       = 1'b0;
      ram_waddr    = req_block_index[IW-1:0];
      ram_wdata    = {req_address, req_item_count};
      ram_re       = 1'b0;
      div_start    = 1'b0;
      div_dvd      = nt_ff[NW-1] ? add_sum[QW-1:0] : nt_ff[QW-1:0];

      // Take a register beat only while idle
      if (csr_valid && (state_ff == S_IDLE)) begin
         bpi_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               idx_in   = '0;
               addr_in  = req_address;
               eaddr_in = req_address;
               first_in = 1'b1;
               // Default result: absent
               res_addr_in = '1;
               res_cnt_in  = '1;
               res_idx_in  = '1;
               res_st_in   = bemt_pkg::ST_MISS;
               unique case (req_type)
                  bemt_pkg::REQ_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (req_idx < CW'(bemt_pkg::MAX_EXTENTS)) begin
                        ram_we = 1'b1;
                        valid_in[req_block_index[IW-1:0]] = 1'b1;
                        if (in_use_ff < req_idx + CW'(1)) begin
                           in_use_in = req_idx + CW'(1);
                        end
                        res_addr_in = (req_address == '1) ? '1
                                    : bemt_pkg::RADDR_W'(req_address);
                        res_cnt_in  = RCW'(req_item_count);
                        res_idx_in  = bemt_pkg::RIDX_W'(req_idx);
                        res_st_in   = bemt_pkg::ST_OK;
                     end
                  end
                  bemt_pkg::REQ_READ: begin
                     if (req_idx >= in_use_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        idx_in   = req_idx;
                        state_in = S_FETCH;
                     end
                  end
                  bemt_pkg::REQ_FIND: begin
                     if (in_use_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     if (in_use_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        res_st_in    = bemt_pkg::ST_PAST;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
               endcase
            end
         end
         S_FETCH: begin
            ram_re   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            ent_addr_in = ld_addr;
            ent_cnt_in  = ld_cnt;
            prod_in     = bemt_pkg::PROD_W'(ld_cnt) * bemt_pkg::PROD_W'(bpi_eff);
            if (op_ff == bemt_pkg::REQ_READ) begin
               rsp_valid_in = 1'b1;
               res_addr_in  = (ld_addr == '1) ? '1 : bemt_pkg::RADDR_W'(ld_addr);
               res_cnt_in   = RCW'(ld_cnt);
               res_idx_in   = bemt_pkg::RIDX_W'(idx_ff);
               res_st_in    = bemt_pkg::ST_OK;
               state_in     = S_IDLE;
            end else begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (op_ff == bemt_pkg::REQ_FIND) begin
               stop_in  = add_sum[AW:0];
               state_in = S_CMP;
            end else begin
               if (first_ff) begin
                  nt_in    = add_sum;
                  first_in = 1'b0;
               end else begin
                  eaddr_in = add_sum[AW-1:0];
               end
               state_in = S_SUB;
            end
         end
         S_CMP: begin
            if ((ent_addr_ff <= addr_ff) && ({1'b0, addr_ff} < stop_ff)) begin
               rsp_valid_in = 1'b1;
               res_addr_in  = (ent_addr_ff == '1) ? '1
                            : bemt_pkg::RADDR_W'(ent_addr_ff);
               res_cnt_in   = RCW'(ent_cnt_ff);
               res_idx_in   = bemt_pkg::RIDX_W'(idx_ff);
               res_st_in    = bemt_pkg::ST_OK;
               state_in     = S_IDLE;
            end else if (idx_nx >= in_use_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_FETCH;
            end
         end
         S_SUB: begin
            nt_in = add_sum;
            if ((ent_cnt_ff == '0) || add_sum[NW-1]) begin
               state_in = S_DIVS;
            end else if (idx_nx >= in_use_ff) begin
               rsp_valid_in = 1'b1;
               res_st_in    = bemt_pkg::ST_PAST;
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_nx;
               state_in = S_FETCH;
            end
         end
         S_DIVS: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               res_addr_in  = bemt_pkg::RADDR_W'(eaddr_ff);
               res_cnt_in   = q_sat;
               res_idx_in   = bemt_pkg::RIDX_W'(idx_ff);
               res_st_in    = bemt_pkg::ST_OK;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         valid_ff     <= '0;
         bpi_ff       <= bemt_pkg::BPI_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         valid_ff     <= valid_in;
         bpi_ff       <= bpi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      addr_ff     <= addr_in;
      first_ff    <= first_in;
      vld_ff      <= valid_ff[idx_ff[IW-1:0]];
      ent_addr_ff <= ent_addr_in;
      ent_cnt_ff  <= ent_cnt_in;
      prod_ff     <= prod_in;
      stop_ff     <= stop_in;
      nt_ff       <= nt_in;
      eaddr_ff    <= eaddr_in;
      res_addr_ff <= res_addr_in;
      res_cnt_ff  <= res_cnt_in;
      res_idx_ff  <= res_idx_in;
      res_st_ff   <= res_st_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_addr  = res_addr_ff;
   assign rsp_result_count = res_cnt_ff;
   assign rsp_result_index = res_idx_ff;
   assign rsp_status       = res_st_ff;

endmodule

`default_nettype wire

// ----- rtl/bemt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bemt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/bemt_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitude only.
// Depends on bemt_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module bemt_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [bemt_pkg::DVD_W-1:0]        dividend,
   input  wire logic [bemt_pkg::BPI_W-1:0]        divisor,
   output logic                                   done,
   output logic      [bemt_pkg::DVD_W-1:0]        quotient
);

   localparam int STEP_W = $clog2(bemt_pkg::DVD_W + 1);

   logic                             run_ff, run_in;
   logic                             done_ff, done_in;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic [bemt_pkg::DVD_W-1:0]       quo_ff, quo_in;
   logic [bemt_pkg::BPI_W-1:0]       rem_ff, rem_in;
   logic [bemt_pkg::BPI_W:0]         trial;
   logic [bemt_pkg::BPI_W:0]         diff;
   logic                             fits;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[bemt_pkg::DVD_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(bemt_pkg::DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (run_ff) begin
         quo_in  = {quo_ff[bemt_pkg::DVD_W-2:0], fits};
         rem_in  = fits ? diff[bemt_pkg::BPI_W-1:0] : trial[bemt_pkg::BPI_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for block_extent_map_translate: directed and random requests.
// Depends on bemt_pkg and the block RTL; predicts each reply and compares field by field.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import bemt_pkg::*;

   typedef struct packed {
      logic [RADDR_W-1:0] addr;
      logic [RCNT_W-1:0]  count;
      logic [RIDX_W-1:0]  index;
      logic [1:0]         status;
   } extent_reply_type;

   localparam logic [ADDR_W-1:0] NO_ADDR   = '1;
   localparam longint            COUNT_HI  = 64'sd4294967295;
   localparam longint            COUNT_LO  = -64'sd4294967296;
   // Longest walk visits all 64 extents and then runs the divider
   localparam int                DRAIN_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_type;
   logic [5:0]                req_block_index;
   logic [ADDR_W-1:0]         req_address;
   logic [ITEM_W-1:0]         req_item_count;
   logic                      rsp_valid;
   logic signed [RADDR_W-1:0] rsp_result_addr;
   logic signed [RCNT_W-1:0]  rsp_result_count;
   logic signed [RIDX_W-1:0]  rsp_result_index;
   logic [1:0]                rsp_status;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [BPI_W-1:0]          csr_data;

   // Shadow copy of the extent table and the item size
   logic [ADDR_W-1:0] tbl_addr  [MAX_EXTENTS];
   logic [ITEM_W-1:0] tbl_items [MAX_EXTENTS];
   int unsigned       slots_used;
   logic [BPI_W-1:0]  item_bytes;

   extent_reply_type  pending_replies[$];
   int                fail_count = 0;

   block_extent_map_translate u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_block_index  (req_block_index),
      .req_address      (req_address),
      .req_item_count   (req_item_count),
      .rsp_valid        (rsp_valid),
      .rsp_result_addr  (rsp_result_addr),
      .rsp_result_count (rsp_result_count),
      .rsp_result_index (rsp_result_index),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Reply prediction
   // ------------------------------------------------------------------
   function automatic longint unsigned item_grain();
      return (item_bytes == 0) ? 64'd1 : 64'(item_bytes);
   endfunction

   function automatic extent_reply_type make_reply(longint a, longint c, longint i,
                                                   logic [1:0] st);
      extent_reply_type r;
      r.addr   = a[RADDR_W-1:0];
      r.count  = c[RCNT_W-1:0];
      r.index  = i[RIDX_W-1:0];
      r.status = st;
      return r;
   endfunction

   function automatic extent_reply_type miss_reply(logic [1:0] st);
      return make_reply(-64'sd1, -64'sd1, -64'sd1, st);
   endfunction

   // All-ones stored address stands for no address
   function automatic longint shown_addr(logic [ADDR_W-1:0] a);
      if (a == NO_ADDR)
         return -64'sd1;
      return longint'(a);
   endfunction

   function automatic extent_reply_type predict_extent_reply(logic [1:0] kind,
         logic [5:0] slot, logic [ADDR_W-1:0] addr, logic [ITEM_W-1:0] items);
      longint unsigned grain, lo, hi;
      longint          off, span, phys, quot;
      int              k;
      bit              done, past;
      extent_reply_type r;
      grain = item_grain();
      r = miss_reply(ST_MISS);
      case (kind)
         REQ_WRITE: begin
            tbl_addr[slot]  = addr;
            tbl_items[slot] = items;
            if (slots_used < int'(slot) + 1)
               slots_used = int'(slot) + 1;
            r = make_reply(shown_addr(addr), longint'(items), longint'(slot), ST_OK);
         end
         REQ_READ: begin
            if (slot < slots_used)
               r = make_reply(shown_addr(tbl_addr[slot]), longint'(tbl_items[slot]),
                              longint'(slot), ST_OK);
         end
         REQ_FIND: begin
            // Scan downward so the lowest matching extent wins
            for (k = int'(slots_used) - 1; k >= 0; k--) begin
               lo = 64'(tbl_addr[k]);
               hi = lo + grain * tbl_items[k];
               if (lo <= addr && addr < hi)
                  r = make_reply(shown_addr(tbl_addr[k]), longint'(tbl_items[k]),
                                 longint'(k), ST_OK);
            end
         end
         default: begin
            if (slots_used == 0) begin
               r = miss_reply(ST_PAST);
            end else begin
               // Walk the extents, consuming each one's bytes from the offset
               k    = 0;
               phys = longint'(addr);
               off  = longint'(addr) - longint'(tbl_addr[0]);
               done = 1'b0;
               past = 1'b0;
               while (!done) begin
                  span = longint'(grain * tbl_items[k]);
                  off -= span;
                  if (span <= 0 || off < 0) begin
                     done = 1'b1;
                  end else begin
                     k++;
                     if (k >= int'(slots_used)) begin
                        past = 1'b1;
                        done = 1'b1;
                     end else begin
                        phys = longint'(tbl_addr[k]) + off;
                     end
                  end
               end
               if (past) begin
                  r = miss_reply(ST_PAST);
               end else begin
                  quot = (-off) / longint'(grain);
                  if (quot > COUNT_HI) quot = COUNT_HI;
                  if (quot < COUNT_LO) quot = COUNT_LO;
                  r = make_reply(longint'(phys[ADDR_W-1:0]), quot, longint'(k), ST_OK);
               end
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Present one request and hold it until the block takes the beat
   task automatic send_request(logic [1:0] kind, logic [5:0] slot,
                               logic [ADDR_W-1:0] addr, logic [ITEM_W-1:0] items);
      @(negedge clock);
      start           = 1'b1;
      req_type        = kind;
      req_block_index = slot;
      req_address     = addr;
      req_item_count  = items;
      do @(posedge clock); while (busy);
      pending_replies.push_back(predict_extent_reply(kind, slot, addr, items));
   endtask

   // Drop start for a random number of cycles, with junk on the fields
   task automatic idle_sender(int pct);
      longint unsigned junk;
      while ($urandom_range(99) < pct) begin
         junk = {$urandom, $urandom};
         @(negedge clock);
         start           = 1'b0;
         req_type        = junk[1:0];
         req_block_index = junk[7:2];
         req_address     = junk[55:8];
         req_item_count  = $urandom;
      end
   endtask

   // Lower start and wait until every expected reply has come back
   task automatic drain_replies(int settle);
      @(negedge clock);
      start = 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_item_bytes(logic [BPI_W-1:0] value);
      drain_replies(4);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      item_bytes = value;
      @(negedge clock);
      csr_valid = 1'b0;
      csr_data  = BPI_W'($urandom);
   endtask

   // ------------------------------------------------------------------
   // Reply checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      extent_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("reply beat with nothing expected: addr %h count %h index %h status %h",
                   rsp_result_addr, rsp_result_count, rsp_result_index, rsp_status);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_result_addr !== want.addr) begin
               $error("result_addr expected %h got %h", want.addr, rsp_result_addr);
               fail_count++;
            end
            if (rsp_result_count !== want.count) begin
               $error("result_count expected %h got %h", want.count, rsp_result_count);
               fail_count++;
            end
            if (rsp_result_index !== want.index) begin
               $error("result_index expected %h got %h", want.index, rsp_result_index);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %h got %h", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Empty table: reads miss, find misses, translate has nothing to walk
   task automatic test_empty_table();
      send_request(REQ_READ,  6'd0,  '0, '0);
      send_request(REQ_READ,  6'd63, '0, '0);
      send_request(REQ_FIND,  6'd0,  '0, '0);
      send_request(REQ_XLATE, 6'd0,  NO_ADDR, '0);
   endtask

   // Writes grow the in-use count; a hole reads back in its reset state
   task automatic test_write_read();
      send_request(REQ_WRITE, 6'd0, 48'h1000, 32'd16);
      send_request(REQ_WRITE, 6'd1, 48'h8000, 32'd8);
      send_request(REQ_WRITE, 6'd3, NO_ADDR, '1);
      send_request(REQ_READ,  6'd2, '0, '0);
      send_request(REQ_READ,  6'd3, '0, '0);
      send_request(REQ_READ,  6'd4, '0, '0);
      send_request(REQ_READ,  6'd0, '0, '0);
   endtask

   // First and last byte of an extent, a gap, and a second extent
   task automatic test_find();
      send_request(REQ_FIND, 6'd0, 48'h1000, '0);
      send_request(REQ_FIND, 6'd0, 48'h100F, '0);
      send_request(REQ_FIND, 6'd0, 48'h1010, '0);
      send_request(REQ_FIND, 6'd0, 48'h8007, '0);
   endtask

   // Walk stops: offset runs out, zero-sized extent, table end; wrap and saturation
   task automatic test_translate();
      send_request(REQ_XLATE, 6'd0, 48'h1000, '0);
      send_request(REQ_XLATE, 6'd0, 48'h1013, '0);
      send_request(REQ_XLATE, 6'd0, 48'h1018, '0);
      send_request(REQ_XLATE, 6'd0, 48'h0FFF, '0);
      send_request(REQ_WRITE, 6'd2, 48'hFFFF_FFFF_FFFE, 32'd4);
      send_request(REQ_WRITE, 6'd3, 48'h2000, 32'd4);
      send_request(REQ_XLATE, 6'd0, 48'h101A, '0);
      send_request(REQ_XLATE, 6'd0, 48'h1028, '0);
      send_request(REQ_WRITE, 6'd1, 48'h8000, 32'd0);
      send_request(REQ_XLATE, 6'd0, NO_ADDR, '0);
      send_request(REQ_WRITE, 6'd0, 48'hF000_0000_0000, 32'd1);
      send_request(REQ_XLATE, 6'd0, 48'h0, '0);
      write_item_bytes(16'hFFFF);
      send_request(REQ_XLATE, 6'd0, 48'hF000_0000_0000, '0);
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      longint unsigned rnd;
      int              roll;
      rnd  = {$urandom, $urandom};
      roll = $urandom_range(99);
      if (roll < 5)  return NO_ADDR;
      if (roll < 8)  return '0;
      if (roll < 35) return rnd[ADDR_W-1:0];
      return 48'h0000_4000_0000 + rnd[19:0];
   endfunction

   function automatic logic [ITEM_W-1:0] pick_count();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)  return '0;
      if (roll < 12) return '1;
      if (roll < 25) return $urandom;
      return $urandom_range(1, 64);
   endfunction

   // Bytes covered by the chain of extents before the first zero-sized one
   function automatic longint unsigned chain_bytes();
      longint unsigned sum;
      int              k;
      sum = 0;
      for (k = 0; k < int'(slots_used); k++) begin
         if (tbl_items[k] == 0) break;
         sum += item_grain() * tbl_items[k];
      end
      return sum;
   endfunction

   // Mostly aim finds and translations into the stored extents
   task automatic random_request(int cap);
      logic [1:0]        kind;
      logic [5:0]        slot;
      logic [ADDR_W-1:0] addr;
      logic [ITEM_W-1:0] items;
      longint unsigned   rnd;
      int                roll, k, top;
      roll  = $urandom_range(99);
      rnd   = {$urandom, $urandom};
      items = pick_count();
      addr  = pick_addr();
      top   = (int'(slots_used) < cap) ? int'(slots_used) : cap;
      slot  = 6'($urandom_range(0, top));
      if (roll < 30) begin
         kind = REQ_WRITE;
      end else if (roll < 50) begin
         kind = REQ_READ;
         if ($urandom_range(4) == 0) slot = 6'($urandom_range(0, 63));
      end else if (roll < 70) begin
         kind = REQ_FIND;
         if (slots_used != 0 && $urandom_range(9) < 6) begin
            k    = $urandom_range(0, int'(slots_used) - 1);
            addr = ADDR_W'(tbl_addr[k] + rnd % (item_grain() * tbl_items[k] + 2));
         end
      end else begin
         kind = REQ_XLATE;
         if (slots_used != 0 && $urandom_range(9) < 7)
            addr = ADDR_W'(tbl_addr[0] + rnd % (chain_bytes() + 4 * item_grain() + 1));
      end
      send_request(kind, slot, addr, items);
   endtask

   // Phases differ in item size, sender idling and how far the table may grow
   task automatic test_random_traffic();
      logic [BPI_W-1:0] sizes [6];
      int               idle_pct [6];
      int               caps [6];
      int               phase, n;
      sizes    = '{16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd1, 16'd7};
      idle_pct = '{0, 79, 0, 9, 79, 0};
      caps     = '{6, 12, 20, 32, 48, 63};
      sizes[4] = BPI_W'($urandom_range(2, 64));
      for (phase = 0; phase < 6; phase++) begin
         write_item_bytes(sizes[phase]);
         for (n = 0; n < 150; n++) begin
            idle_sender(idle_pct[phase]);
            random_request(caps[phase]);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int k;
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_WRITE;
      req_block_index = '0;
      req_address     = '0;
      req_item_count  = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      for (k = 0; k < MAX_EXTENTS; k++) begin
         tbl_addr[k]  = NO_ADDR;
         tbl_items[k] = '0;
      end
      slots_used = 0;
      item_bytes = 16'd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_write_read();
      test_find();
      test_translate();
      test_random_traffic();

      drain_replies(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #6_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
